[hw/rtl/ping_pong_capture_block_queue_defines.svh]
// Assertion macros shared by the ping-pong capture block queue RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef PING_PONG_CAPTURE_BLOCK_QUEUE_DEFINES_SVH
`define PING_PONG_CAPTURE_BLOCK_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PPCBQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("check failed in %m");
// Check that a condition leads to a consequence in the next cycle.
`define PPCBQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed in %m");
`else
`define PPCBQ_ASSERT(lbl, clk, rst, prop)
`define PPCBQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/ppcbq_pkg.sv]
// Shared types and constants for the ping-pong capture block queue.
// No dependencies; used by ppcbq_ctrl, ppcbq_dp and the top level.
`default_nettype none

package ppcbq_pkg;

  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 32;
  localparam int LEVEL_W  = 5;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_sample;
    logic take_pop;
    logic take_clear;
    logic copy_run;
    logic pop_run;
    logic empty_run;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic enq_hit;
    logic queue_empty;
    logic copy_done;
    logic pop_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/ping_pong_capture_block_queue.sv]
// A sample, clear or unused kind is taken while idle; a sample that queues a block
// then runs a copy sweep through the ring read port into the block store.
// A pop holds the input through a sweep with one block-store read per result,
// paced by the output; a pop from an empty queue returns a single empty result.
// Items are taken one at a time. Reset clears positions, queue and counters.
`default_nettype none

module ping_pong_capture_block_queue #(
  parameter int BLOCK_SAMPLES = 32,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ppcbq_pkg::KIND_W-1:0]    kind,
  input  wire logic [ppcbq_pkg::SAMPLE_W-1:0]  sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 valid_res,
  output logic [ppcbq_pkg::SAMPLE_W-1:0]       sample_out,
  output logic [ppcbq_pkg::CNT_W-1:0]          block_seq,
  output logic                                 block_part,
  output logic                                 last,
  output logic [ppcbq_pkg::CNT_W-1:0]          half_events,
  output logic [ppcbq_pkg::CNT_W-1:0]          full_events,
  output logic [ppcbq_pkg::CNT_W-1:0]          dropped_blocks,
  output logic [ppcbq_pkg::CNT_W-1:0]          frame_seq,
  output logic [ppcbq_pkg::LEVEL_W-1:0]        queue_level
);

  ppcbq_pkg::cmd_t    cmd;
  ppcbq_pkg::status_t status;

  ppcbq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  ppcbq_dp #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .valid_res      (valid_res),
    .sample_out     (sample_out),
    .block_seq      (block_seq),
    .block_part     (block_part),
    .last           (last),
    .half_events    (half_events),
    .full_events    (full_events),
    .dropped_blocks (dropped_blocks),
    .frame_seq      (frame_seq),
    .queue_level    (queue_level)
  );

endmodule

`default_nettype wire

[hw/rtl/ppcbq_ctrl.sv]
// Controller state machine for the ping-pong capture block queue.
// Depends on ppcbq_pkg for kind codes and the command/status structs.
`default_nettype none

module ppcbq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ppcbq_pkg::KIND_W-1:0]  kind,
  input  wire ppcbq_pkg::status_t            status,
  output ppcbq_pkg::cmd_t                    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_COPY  = 4'b0010,
    ST_POP   = 4'b0100,
    ST_EMPTY = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign in_ready = (state == ST_IDLE);
  assign take     = in_valid && in_ready;

  // Decode commands for the datapath
  always_comb begin
    cmd.take_sample = take && (kind == ppcbq_pkg::KIND_SAMPLE);
    cmd.take_pop    = take && (kind == ppcbq_pkg::KIND_POP);
    cmd.take_clear  = take && (kind == ppcbq_pkg::KIND_CLEAR);
    cmd.copy_run    = (state == ST_COPY);
    cmd.pop_run     = (state == ST_POP);
    cmd.empty_run   = (state == ST_EMPTY);
  end

  // Advance the state on accepted transfers, finished sweeps and loaded empty results
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.take_sample && status.enq_hit) begin
          state_next = ST_COPY;
        end else if (cmd.take_pop) begin
          state_next = status.queue_empty ? ST_EMPTY : ST_POP;
        end
      end
      ST_COPY: begin
        if (status.copy_done) state_next = ST_IDLE;
      end
      ST_POP: begin
        if (status.pop_done) state_next = ST_IDLE;
      end
      ST_EMPTY: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ppcbq_dp.sv]
// Datapath for the ping-pong capture block queue: capture ring, block store,
// queue bookkeeping, event counters and the output register. Uses ppcbq_pkg.
`default_nettype none
`include "ping_pong_capture_block_queue_defines.svh"

module ppcbq_dp #(
  parameter int BLOCK_SAMPLES = 32,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ppcbq_pkg::cmd_t                 cmd,
  output ppcbq_pkg::status_t                   status,
  input  wire logic [ppcbq_pkg::SAMPLE_W-1:0]  sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 valid_res,
  output logic [ppcbq_pkg::SAMPLE_W-1:0]       sample_out,
  output logic [ppcbq_pkg::CNT_W-1:0]          block_seq,
  output logic                                 block_part,
  output logic                                 last,
  output logic [ppcbq_pkg::CNT_W-1:0]          half_events,
  output logic [ppcbq_pkg::CNT_W-1:0]          full_events,
  output logic [ppcbq_pkg::CNT_W-1:0]          dropped_blocks,
  output logic [ppcbq_pkg::CNT_W-1:0]          frame_seq,
  output logic [ppcbq_pkg::LEVEL_W-1:0]        queue_level
);

  localparam int RING      = 2 * BLOCK_SAMPLES;
  localparam int RAW       = $clog2(RING);
  localparam int BLK_DEPTH = QUEUE_DEPTH * BLOCK_SAMPLES;
  localparam int BAW       = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
  localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int HW        = $clog2(QUEUE_DEPTH + 1);
  localparam int KW        = $clog2(BLOCK_SAMPLES + 1);
  localparam int SW        = ppcbq_pkg::SAMPLE_W;
  localparam int CW        = ppcbq_pkg::CNT_W;
  localparam int LW        = ppcbq_pkg::LEVEL_W;

  // Storage
  logic [SW-1:0] ring_mem  [RING];
  logic [SW-1:0] blk_mem   [BLK_DEPTH];
  logic [CW-1:0] slot_seq  [QUEUE_DEPTH];
  logic          slot_part [QUEUE_DEPTH];

  // Control registers
  logic [RAW-1:0] pos;
  logic [QW-1:0]  head;
  logic [QW-1:0]  tail;
  logic [HW-1:0]  held;
  logic [CW-1:0]  half_cnt;
  logic [CW-1:0]  full_cnt;
  logic [CW-1:0]  drop_cnt;
  logic [CW-1:0]  seq_cnt;
  logic [CW-1:0]  frame_cnt;
  logic [KW-1:0]  k;
  logic           wr_pend;
  logic           rd_pend;
  logic           rd_pend_next;

  // Payload registers
  logic [QW-1:0]  cur_slot;
  logic [CW-1:0]  cur_seq;
  logic           cur_part;
  logic           copy_part;
  logic [SW-1:0]  ring_rd;
  logic [BAW-1:0] wr_addr;
  logic [SW-1:0]  blk_rd;
  logic           rd_last;

  // Combinational helpers
  logic [RAW:0]   pos_inc;
  logic           hit_half;
  logic           hit_full;
  logic           hit_any;
  logic           q_full;
  logic [QW-1:0]  head_inc;
  logic [QW-1:0]  tail_inc;
  logic           k_lt;
  logic [RAW-1:0] ring_raddr;
  logic [BAW-1:0] blk_addr;
  logic           cp_issue;
  logic           pp_issue;
  logic           load;
  logic           out_free;
  logic           empty_load;

  // Ring position and half completion
  assign pos_inc  = (RAW+1)'(pos) + (RAW+1)'(1);
  assign hit_half = (pos_inc == (RAW+1)'(BLOCK_SAMPLES));
  assign hit_full = (pos_inc == (RAW+1)'(RING));
  assign hit_any  = hit_half || hit_full;
  assign q_full   = (held == HW'(QUEUE_DEPTH));

  assign head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
  assign tail_inc = (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + QW'(1);

  // Sweep addressing shared by copy and pop
  assign k_lt       = (k != KW'(BLOCK_SAMPLES));
  assign ring_raddr = (copy_part ? RAW'(BLOCK_SAMPLES) : RAW'(0)) + RAW'(k);
  assign blk_addr   = BAW'(cur_slot) * BAW'(BLOCK_SAMPLES) + BAW'(k);

  // Issue reads; pop reads only when the fetched word has a place to go
  assign out_free     = !out_valid || out_ready;
  assign load         = rd_pend && out_free;
  assign cp_issue     = cmd.copy_run && k_lt;
  assign pp_issue     = cmd.pop_run && k_lt && (!rd_pend || load);
  assign rd_pend_next = pp_issue || (rd_pend && !load);
  assign empty_load   = cmd.empty_run && out_free;

  always_comb begin
    status.enq_hit     = hit_any && !q_full;
    status.queue_empty = (held == '0);
    status.copy_done   = cmd.copy_run && !k_lt;
    status.pop_done    = cmd.pop_run && !k_lt && !rd_pend;
    status.out_free    = out_free;
  end

  // Queue bookkeeping, counters and sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      half_cnt  <= '0;
      full_cnt  <= '0;
      drop_cnt  <= '0;
      seq_cnt   <= '0;
      frame_cnt <= '0;
      k         <= '0;
      wr_pend   <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take_sample) begin
        pos <= hit_full ? '0 : pos_inc[RAW-1:0];
        if (hit_half) half_cnt <= half_cnt + CW'(1);
        if (hit_full) begin
          full_cnt  <= full_cnt + CW'(1);
          frame_cnt <= frame_cnt + CW'(1);
        end
        if (hit_any) begin
          if (q_full) begin
            drop_cnt <= drop_cnt + CW'(1);
          end else begin
            seq_cnt <= seq_cnt + CW'(1);
            head    <= head_inc;
            held    <= held + HW'(1);
          end
        end
      end
      if (cmd.take_clear) begin
        half_cnt <= '0;
        full_cnt <= '0;
        drop_cnt <= '0;
      end
      if (cmd.take_pop && held != '0) begin
        tail <= tail_inc;
        held <= held - HW'(1);
      end
      if (cmd.take_sample || cmd.take_pop) begin
        k <= '0;
      end else if (cp_issue || pp_issue) begin
        k <= k + KW'(1);
      end
      wr_pend <= cp_issue;
      rd_pend <= rd_pend_next;
      if (load || empty_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Slot tags and sweep payload
  always_ff @(posedge clk) begin
    if (cmd.take_sample && hit_any && !q_full) begin
      slot_seq[head]  <= seq_cnt + CW'(1);
      slot_part[head] <= hit_full;
      cur_slot        <= head;
      copy_part       <= hit_full;
    end
    if (cmd.take_pop) begin
      cur_slot <= tail;
      cur_seq  <= slot_seq[tail];
      cur_part <= slot_part[tail];
    end
  end

  // Capture ring: write on sample transfer, read during the copy sweep
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      ring_mem[pos] <= sample;
    end
    if (cp_issue) begin
      ring_rd <= ring_mem[ring_raddr];
      wr_addr <= blk_addr;
    end
  end

  // Block store: written in the cycle after each ring read, read during pop
  always_ff @(posedge clk) begin
    if (wr_pend) begin
      blk_mem[wr_addr] <= ring_rd;
    end
    if (pp_issue) begin
      blk_rd  <= blk_mem[blk_addr];
      rd_last <= (k == KW'(BLOCK_SAMPLES - 1));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      valid_res      <= 1'b1;
      sample_out     <= blk_rd;
      block_seq      <= cur_seq;
      block_part     <= cur_part;
      last           <= rd_last;
      half_events    <= half_cnt;
      full_events    <= full_cnt;
      dropped_blocks <= drop_cnt;
      frame_seq      <= frame_cnt;
      queue_level    <= LW'(held);
    end else if (empty_load) begin
      valid_res      <= 1'b0;
      sample_out     <= '0;
      block_seq      <= '0;
      block_part     <= 1'b0;
      last           <= 1'b1;
      half_events    <= half_cnt;
      full_events    <= full_cnt;
      dropped_blocks <= drop_cnt;
      frame_seq      <= frame_cnt;
      queue_level    <= '0;
    end
  end

  // Queue never holds more blocks than it has slots
  `PPCBQ_ASSERT(a_held_range, clk, rst, held <= HW'(QUEUE_DEPTH))
  // Copy writes and pop reads of the block store never overlap
  `PPCBQ_ASSERT(a_sweep_excl, clk, rst, !(wr_pend && rd_pend))
  // A pop from a non-empty queue releases exactly one block
  `PPCBQ_ASSERT_NEXT(a_pop_level, clk, rst, cmd.take_pop && !status.queue_empty, (held + HW'(1)) == $past(held))
  // The last word of a block is loaded only once the sweep has ended
  `PPCBQ_ASSERT(a_last_end, clk, rst, !(load && rd_last) || (k == KW'(BLOCK_SAMPLES)))

endmodule

`default_nettype wire

[test/ppcbq_scoreboard.sv]
// Scoreboard for the ping-pong capture block queue: watches both transfer
// channels, predicts every block read and compares it field by field.
// Depends on ppcbq_pkg for the item kinds and field widths.
`default_nettype none

module ppcbq_scoreboard #(
  parameter int BLOCK_SAMPLES = 32,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [ppcbq_pkg::KIND_W-1:0]    kind,
  input  wire logic [ppcbq_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic                            valid_res,
  input  wire logic [ppcbq_pkg::SAMPLE_W-1:0]  sample_out,
  input  wire logic [ppcbq_pkg::CNT_W-1:0]     block_seq,
  input  wire logic                            block_part,
  input  wire logic                            last,
  input  wire logic [ppcbq_pkg::CNT_W-1:0]     half_events,
  input  wire logic [ppcbq_pkg::CNT_W-1:0]     full_events,
  input  wire logic [ppcbq_pkg::CNT_W-1:0]     dropped_blocks,
  input  wire logic [ppcbq_pkg::CNT_W-1:0]     frame_seq,
  input  wire logic [ppcbq_pkg::LEVEL_W-1:0]   queue_level,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   compared
);

  localparam int RING_LEN = 2 * BLOCK_SAMPLES;
  localparam int SAMPLE_W = ppcbq_pkg::SAMPLE_W;
  localparam int CNT_W    = ppcbq_pkg::CNT_W;
  localparam int LEVEL_W  = ppcbq_pkg::LEVEL_W;
  localparam int KIND_W   = ppcbq_pkg::KIND_W;

  typedef struct {
    logic                valid;
    logic [SAMPLE_W-1:0] smp;
    logic [CNT_W-1:0]    seq;
    logic                part;
    logic                fin;
    logic [CNT_W-1:0]    half;
    logic [CNT_W-1:0]    full;
    logic [CNT_W-1:0]    drop;
    logic [CNT_W-1:0]    frame;
    logic [LEVEL_W-1:0]  level;
  } block_read_t;

  // Shadow copy of the capture ring, the block queue and the event counters
  logic [SAMPLE_W-1:0] ring_img [RING_LEN];
  logic [SAMPLE_W-1:0] slot_img [QUEUE_DEPTH * BLOCK_SAMPLES];
  logic [CNT_W-1:0]    slot_seq_img [QUEUE_DEPTH];
  logic                slot_part_img [QUEUE_DEPTH];
  int                  wr_pos;
  int                  head_slot;
  int                  tail_slot;
  int                  held;
  logic [CNT_W-1:0]    half_cnt;
  logic [CNT_W-1:0]    full_cnt;
  logic [CNT_W-1:0]    drop_cnt;
  logic [CNT_W-1:0]    seq_cnt;
  logic [CNT_W-1:0]    frame_cnt;

  block_read_t expected_reads [$];

  // Copy one ring half into the next free slot, or count it as lost
  task automatic stage_half(input int base, input logic part);
    int slot;
    if (held >= QUEUE_DEPTH) begin
      drop_cnt = drop_cnt + 1;
    end else begin
      slot = head_slot;
      seq_cnt = seq_cnt + 1;
      slot_seq_img[slot] = seq_cnt;
      slot_part_img[slot] = part;
      for (int i = 0; i < BLOCK_SAMPLES; i++)
        slot_img[slot * BLOCK_SAMPLES + i] = ring_img[(base + i) % RING_LEN];
      head_slot = (slot + 1) % QUEUE_DEPTH;
      held = held + 1;
    end
  endtask

  // Advance the shadow state by one accepted item and queue its reads
  task automatic predict_item(input logic [KIND_W-1:0] k,
                              input logic [SAMPLE_W-1:0] s);
    block_read_t r;
    int slot;
    case (k)
      ppcbq_pkg::KIND_SAMPLE: begin
        ring_img[wr_pos] = s;
        wr_pos = wr_pos + 1;
        if (wr_pos == BLOCK_SAMPLES) begin
          half_cnt = half_cnt + 1;
          stage_half(0, 1'b0);
        end
        if (wr_pos >= RING_LEN) begin
          full_cnt = full_cnt + 1;
          stage_half(BLOCK_SAMPLES, 1'b1);
          frame_cnt = frame_cnt + 1;
          wr_pos = 0;
        end
      end
      ppcbq_pkg::KIND_POP: begin
        r.half  = half_cnt;
        r.full  = full_cnt;
        r.drop  = drop_cnt;
        r.frame = frame_cnt;
        if (held == 0) begin
          r.valid = 1'b0;
          r.smp   = '0;
          r.seq   = '0;
          r.part  = 1'b0;
          r.fin   = 1'b1;
          r.level = '0;
          expected_reads.push_back(r);
        end else begin
          slot = tail_slot;
          tail_slot = (slot + 1) % QUEUE_DEPTH;
          held = held - 1;
          r.valid = 1'b1;
          r.seq   = slot_seq_img[slot];
          r.part  = slot_part_img[slot];
          r.level = LEVEL_W'(held);
          for (int i = 0; i < BLOCK_SAMPLES; i++) begin
            r.smp = slot_img[slot * BLOCK_SAMPLES + i];
            r.fin = (i == BLOCK_SAMPLES - 1);
            expected_reads.push_back(r);
          end
        end
      end
      ppcbq_pkg::KIND_CLEAR: begin
        half_cnt = '0;
        full_cnt = '0;
        drop_cnt = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_count = fail_count + 1;
      if (fail_count <= 10)
        $display("mismatch on %s at read %0d: expected %0h, got %0h",
                 name, compared, exp_v, act_v);
    end
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    block_read_t want;
    if (rst) begin
      wr_pos     = 0;
      head_slot  = 0;
      tail_slot  = 0;
      held       = 0;
      half_cnt   = '0;
      full_cnt   = '0;
      drop_cnt   = '0;
      seq_cnt    = '0;
      frame_cnt  = '0;
      fail_count = 0;
      compared   = 0;
      expected_reads.delete();
    end else begin
      if (in_valid && in_ready)
        predict_item(kind, sample);
      if (out_valid && out_ready) begin
        if (expected_reads.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("unexpected read: sample %0h seq %0d last %0b",
                     sample_out, block_seq, last);
        end else begin
          want = expected_reads.pop_front();
          check_field("valid_res", CNT_W'(want.valid), CNT_W'(valid_res));
          check_field("sample_out", CNT_W'(want.smp), CNT_W'(sample_out));
          check_field("block_seq", want.seq, block_seq);
          check_field("block_part", CNT_W'(want.part), CNT_W'(block_part));
          check_field("last", CNT_W'(want.fin), CNT_W'(last));
          check_field("half_events", want.half, half_events);
          check_field("full_events", want.full, full_events);
          check_field("dropped_blocks", want.drop, dropped_blocks);
          check_field("frame_seq", want.frame, frame_seq);
          check_field("queue_level", CNT_W'(want.level), CNT_W'(queue_level));
          compared = compared + 1;
        end
      end
    end
    pending = expected_reads.size();
  end

endmodule

`default_nettype wire

[test/tb_ping_pong_capture_block_queue.sv]
// Top of the ping-pong capture block queue testbench: clock, reset, stimulus
// and verdict. Depends on ppcbq_pkg, the block and ppcbq_scoreboard.
`default_nettype none

module tb_ping_pong_capture_block_queue;

  localparam int BLOCK_SAMPLES = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int KIND_W        = ppcbq_pkg::KIND_W;
  localparam int SAMPLE_W      = ppcbq_pkg::SAMPLE_W;
  localparam int CNT_W         = ppcbq_pkg::CNT_W;
  localparam int LEVEL_W       = ppcbq_pkg::LEVEL_W;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 300;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = ppcbq_pkg::KIND_SAMPLE;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic                valid_res;
  logic [SAMPLE_W-1:0] sample_out;
  logic [CNT_W-1:0]    block_seq;
  logic                block_part;
  logic                last;
  logic [CNT_W-1:0]    half_events;
  logic [CNT_W-1:0]    full_events;
  logic [CNT_W-1:0]    dropped_blocks;
  logic [CNT_W-1:0]    frame_seq;
  logic [LEVEL_W-1:0]  queue_level;

  int fail_count;
  int pending;
  int compared;

  // Idle control: quiet for the tail of the run, calm for random stretches
  bit quiet = 1'b0;
  bit calm  = 1'b0;
  int stall_left = 0;
  int n_samples = 0;
  int n_pops    = 0;
  int n_clears  = 0;
  int n_unused  = 0;

  ping_pong_capture_block_queue #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valid_res     (valid_res),
    .sample_out    (sample_out),
    .block_seq     (block_seq),
    .block_part    (block_part),
    .last          (last),
    .half_events   (half_events),
    .full_events   (full_events),
    .dropped_blocks(dropped_blocks),
    .frame_seq     (frame_seq),
    .queue_level   (queue_level)
  );

  ppcbq_scoreboard #(
    .BLOCK_SAMPLES(BLOCK_SAMPLES),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) scoreboard (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valid_res     (valid_res),
    .sample_out    (sample_out),
    .block_seq     (block_seq),
    .block_part    (block_part),
    .last          (last),
    .half_events   (half_events),
    .full_events   (full_events),
    .dropped_blocks(dropped_blocks),
    .frame_seq     (frame_seq),
    .queue_level   (queue_level),
    .fail_count    (fail_count),
    .pending       (pending),
    .compared      (compared)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side in bursts at random
  always @(negedge clk) begin
    if (stall_left > 0)
      stall_left = stall_left - 1;
    else if (!rst && !quiet && !calm && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 5);
    out_ready <= (stall_left == 0);
  end

  // Present one item at a falling edge and hold it until the transfer
  task automatic transfer_item(input logic [KIND_W-1:0] k,
                               input logic [SAMPLE_W-1:0] s);
    int gap;
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    case (k)
      ppcbq_pkg::KIND_SAMPLE: n_samples++;
      ppcbq_pkg::KIND_POP:    n_pops++;
      ppcbq_pkg::KIND_CLEAR:  n_clears++;
      default:                n_unused++;
    endcase
  endtask

  // Stream samples, with the odd clear or unused item mixed in
  task automatic pour_samples(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0)
        transfer_item($urandom_range(0, 1) ? ppcbq_pkg::KIND_CLEAR : KIND_UNUSED,
                      16'($urandom));
      transfer_item(ppcbq_pkg::KIND_SAMPLE, 16'($urandom));
    end
  endtask

  task automatic drain_pops(input int count);
    repeat (count) transfer_item(ppcbq_pkg::KIND_POP, 16'($urandom));
  endtask

  initial begin
    int pick;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty pop, unused kind, clear, sample extremes
    transfer_item(ppcbq_pkg::KIND_POP, 16'h0000);
    transfer_item(KIND_UNUSED, 16'hFFFF);
    transfer_item(ppcbq_pkg::KIND_CLEAR, 16'hFFFF);
    transfer_item(ppcbq_pkg::KIND_SAMPLE, 16'h0000);
    transfer_item(ppcbq_pkg::KIND_SAMPLE, 16'hFFFF);
    transfer_item(ppcbq_pkg::KIND_SAMPLE, 16'hAAAA);
    transfer_item(ppcbq_pkg::KIND_SAMPLE, 16'h5555);
    transfer_item(ppcbq_pkg::KIND_SAMPLE, 16'h8000);
    transfer_item(ppcbq_pkg::KIND_SAMPLE, 16'h0001);
    transfer_item(ppcbq_pkg::KIND_POP, 16'hFFFF);
    transfer_item(ppcbq_pkg::KIND_CLEAR, 16'h0000);

    // Overfill the queue so a block is dropped, clear, then drain past empty
    pour_samples(170);
    transfer_item(ppcbq_pkg::KIND_CLEAR, 16'($urandom));
    drain_pops(QUEUE_DEPTH + 1);

    // Random segments of sample streams, pop runs and mixed items
    while (n_samples + n_pops + n_clears < RANDOM_ITEMS + 10) begin
      quiet = (n_samples + n_pops + n_clears >= RANDOM_ITEMS - 30);
      calm  = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 9);
      if (pick < 5) begin
        pour_samples($urandom_range(4, 90));
      end else if (pick < 8) begin
        drain_pops($urandom_range(1, 5));
      end else begin
        repeat (12) begin
          pick = $urandom_range(0, 19);
          if (pick < 14)      transfer_item(ppcbq_pkg::KIND_SAMPLE, 16'($urandom));
          else if (pick < 18) transfer_item(ppcbq_pkg::KIND_POP, 16'($urandom));
          else if (pick < 19) transfer_item(ppcbq_pkg::KIND_CLEAR, 16'($urandom));
          else                transfer_item(KIND_UNUSED, 16'($urandom));
        end
      end
    end
    in_valid <= 1'b0;

    // Let the last block drain, then watch for stray reads
    while (pending != 0) @(posedge clk);
    repeat (BLOCK_SAMPLES + 8) @(posedge clk);

    $display("Sent %0d samples, %0d pops, %0d clears and %0d unused items.",
             n_samples, n_pops, n_clears, n_unused);
    $display("Compared %0d block reads; %0d field errors.", compared, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
